// File: rtl/multi_waveform_test_oscillator_defines.svh
// Assertion macros shared by the oscillator RTL.
`ifndef MULTI_WAVEFORM_TEST_OSCILLATOR_DEFINES_SVH
`define MULTI_WAVEFORM_TEST_OSCILLATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, quiet while reset is high.
`define MWTO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define MWTO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MWTO_ASSERT(label, prop, msg)
`define MWTO_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/mwto_pkg.sv
// Shared constants and types of the multi-waveform test oscillator.
package mwto_pkg;

  localparam int MAX_BLOCK_DEFAULT   = 64;
  localparam int SINE_DEPTH_DEFAULT  = 1024;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;
  localparam int VALUE_BITS     = 33;
  localparam int GAIN_BITS      = 16;
  localparam int LEN_BITS       = 7;

  localparam logic [2:0] WAVE_SINE    = 3'd0;
  localparam logic [2:0] WAVE_SQUARE  = 3'd1;
  localparam logic [2:0] WAVE_SAW     = 3'd2;
  localparam logic [2:0] WAVE_NOISE   = 3'd3;
  localparam logic [2:0] WAVE_IMPULSE = 3'd4;
  localparam logic [2:0] WAVE_SILENCE = 3'd5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_GAIN = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOISE_SEED = CFG_INDEX_BITS'(3);

  localparam logic [30:0]          STEP_RESET = 31'd19685268;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd8231;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 16'h8000;
  localparam logic [31:0]          SEED_RESET = 32'd2463534242;

  localparam logic [63:0]        HALF_PI_Q31 = 64'hC90F_DAA2;
  localparam logic signed [63:0] ONE_Q31_64  = 64'sh8000_0000;

  // Configuration seen by the waveform generator.
  typedef struct packed {
    logic [2:0]  waveform;
    logic [30:0] phase_step;
  } wave_cfg_t;

  // Per-sample control from the sequencer, and the seed load from the cfg channel, to the waveform generator.
  typedef struct packed {
    logic        gen;
    logic        quiet;
    logic        seed_load;
    logic [31:0] seed;
  } wave_ctrl_t;

endpackage

// File: rtl/multi_waveform_test_oscillator.sv
// Top level of the multi-waveform test oscillator: registers, sequencer, output stage.
//
// A request item on the req channel carries block_length; the block answers with
// that many sample items on the smp channel (lengths above MAX_BLOCK are clipped,
// a length of zero produces nothing) and raises last_of_block on the final one.
// Both channels use valid and stall; an item moves on a clock edge with valid high
// and stall low. req_stall is high while a block is being produced, so one request
// is worked on at a time. The cfg channel writes waveform, phase_step, level_gain
// and noise_seed (indexes 0 to 3); other indexes are ignored. cfg_ready is always
// high, and writes are meant to happen only between blocks.
// Each sample passes through the sequencer states in order: phase and noise update
// with the sine table read, one pass through the shared gain multiplier, rounding
// into the output register, and the output handshake. A stall on smp simply holds
// the sample in the output register and freezes the sequencer. Reset clears the
// phase, reloads the default seed and settings, and leaves the block idle and
// ready for a request.
`include "multi_waveform_test_oscillator_defines.svh"

module multi_waveform_test_oscillator #(
  parameter int MAX_BLOCK        = mwto_pkg::MAX_BLOCK_DEFAULT,
  parameter int SINE_TABLE_DEPTH = mwto_pkg::SINE_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS      = mwto_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [mwto_pkg::LEN_BITS-1:0]         block_length,
  output logic                                  smp_valid,
  input  logic                                  smp_stall,
  output logic signed [SAMPLE_BITS-1:0]         sample,
  output logic                                  last_of_block,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mwto_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [mwto_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int FW = $clog2(MAX_BLOCK + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GEN  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                              state;
  logic [FW-1:0]                           frames_left;
  logic [2:0]                              waveform;
  logic [30:0]                             phase_step;
  logic [mwto_pkg::GAIN_BITS-1:0]          level_gain;
  logic [mwto_pkg::GAIN_BITS-1:0]          gain_eff;
  logic [mwto_pkg::LEN_BITS-1:0]           len_clip;
  logic                                    cfg_write;
  logic                                    req_take;
  logic                                    smp_take;
  logic                                    quiet;
  logic signed [mwto_pkg::VALUE_BITS-1:0]  wave_value;
  logic signed [SAMPLE_BITS-1:0]           scaled;
  mwto_pkg::wave_cfg_t                     wave_cfg;
  mwto_pkg::wave_ctrl_t                    wave_ctrl;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign smp_take  = smp_valid && !smp_stall;

  // Gains above unity are clipped to unity; silence or zero gain freezes the generator.
  assign gain_eff = (level_gain > mwto_pkg::GAIN_MAX) ? mwto_pkg::GAIN_MAX : level_gain;
  assign quiet    = (waveform == mwto_pkg::WAVE_SILENCE) || (gain_eff == '0);
  assign len_clip = (block_length > mwto_pkg::LEN_BITS'(MAX_BLOCK))
                    ? mwto_pkg::LEN_BITS'(MAX_BLOCK) : block_length;

  // Configuration registers. The noise seed is not kept here: a write loads the
  // noise generator directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform   <= mwto_pkg::WAVE_SINE;
      phase_step <= mwto_pkg::STEP_RESET;
      level_gain <= mwto_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mwto_pkg::REG_WAVEFORM:   waveform   <= cfg_data[2:0];
        mwto_pkg::REG_PHASE_STEP: phase_step <= cfg_data[30:0];
        mwto_pkg::REG_LEVEL_GAIN: level_gain <= cfg_data[mwto_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign wave_cfg.waveform   = waveform;
  assign wave_cfg.phase_step = phase_step;

  assign wave_ctrl.gen       = (state == S_GEN);
  assign wave_ctrl.quiet     = quiet;
  assign wave_ctrl.seed_load = cfg_write && (cfg_index == mwto_pkg::REG_NOISE_SEED);
  assign wave_ctrl.seed      = cfg_data;

  mwto_wave #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_wave (
    .clk  (clk),
    .rst  (rst),
    .cfg  (wave_cfg),
    .ctrl (wave_ctrl),
    .value(wave_value)
  );

  mwto_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk   (clk),
    .mul_en(state == S_MUL),
    .value (wave_value),
    .gain  (gain_eff),
    .scaled(scaled)
  );

  // Sequencer: one sample per pass through GEN, MUL, RND and OUT.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frames_left <= '0;
      smp_valid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take && len_clip != '0) begin
            frames_left <= FW'(len_clip);
            state       <= S_GEN;
          end
        end
        S_GEN: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_RND;
        end
        S_RND: begin
          smp_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (smp_take) begin
            smp_valid   <= 1'b0;
            frames_left <= frames_left - FW'(1);
            state       <= (frames_left == FW'(1)) ? S_IDLE : S_GEN;
          end
        end
        default: begin
          state     <= S_IDLE;
          smp_valid <= 1'b0;
        end
      endcase
    end
  end

  // Output register, loaded once per sample and held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (state == S_RND) begin
      sample        <= scaled;
      last_of_block <= (frames_left == FW'(1));
    end
  end

  `MWTO_ASSERT(a_valid_only_in_out, smp_valid |-> (state == S_OUT), "sample valid outside output state")
  `MWTO_ASSERT(a_last_ends_block, (smp_take && last_of_block) |=> (state == S_IDLE), "block did not end after last sample")
  `MWTO_ASSERT(a_busy_has_frames, (state != S_IDLE) |-> (frames_left != '0), "busy with no samples left")
  `MWTO_ASSERT_ALWAYS(a_reset_idle, rst |=> (!smp_valid && !req_stall), "block not idle after reset")

endmodule

// File: rtl/mwto_wave.sv
// Phase accumulator, noise generator, sine table and waveform value select.
module mwto_wave #(
  parameter int SINE_TABLE_DEPTH = mwto_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mwto_pkg::wave_cfg_t                    cfg,
  input  mwto_pkg::wave_ctrl_t                   ctrl,
  output logic signed [mwto_pkg::VALUE_BITS-1:0] value
);

  localparam int KB = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
  localparam int DB = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic signed [mwto_pkg::VALUE_BITS-1:0] ONE = 33'sh0_8000_0000;

  typedef logic signed [mwto_pkg::VALUE_BITS-1:0] rom_t [SINE_TABLE_DEPTH];

  // One full sine cycle in Q1.31, quadrant reduced, Taylor series to order 18.
  function automatic rom_t build_sine();
    rom_t               rom;
    logic [63:0]        u;
    logic [63:0]        quad;
    logic [63:0]        rem;
    logic [63:0]        ang;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic signed [63:0] v;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      u    = 64'(k) * 64'd4;
      quad = u / SINE_TABLE_DEPTH;
      rem  = u % SINE_TABLE_DEPTH;
      ang  = (mwto_pkg::HALF_PI_Q31 * rem) / SINE_TABLE_DEPTH;
      term = ang;
      s    = $signed(ang);
      c    = mwto_pkg::ONE_Q31_64;
      term = ((term * ang) >> 31) / 2;  c = c - $signed(term);
      term = ((term * ang) >> 31) / 3;  s = s - $signed(term);
      term = ((term * ang) >> 31) / 4;  c = c + $signed(term);
      term = ((term * ang) >> 31) / 5;  s = s + $signed(term);
      term = ((term * ang) >> 31) / 6;  c = c - $signed(term);
      term = ((term * ang) >> 31) / 7;  s = s - $signed(term);
      term = ((term * ang) >> 31) / 8;  c = c + $signed(term);
      term = ((term * ang) >> 31) / 9;  s = s + $signed(term);
      term = ((term * ang) >> 31) / 10; c = c - $signed(term);
      term = ((term * ang) >> 31) / 11; s = s - $signed(term);
      term = ((term * ang) >> 31) / 12; c = c + $signed(term);
      term = ((term * ang) >> 31) / 13; s = s + $signed(term);
      term = ((term * ang) >> 31) / 14; c = c - $signed(term);
      term = ((term * ang) >> 31) / 15; s = s - $signed(term);
      term = ((term * ang) >> 31) / 16; c = c + $signed(term);
      term = ((term * ang) >> 31) / 17; s = s + $signed(term);
      term = ((term * ang) >> 31) / 18; c = c - $signed(term);
      v = quad[0] ? c : s;
      if (v < 0) v = 64'sd0;
      if (v > mwto_pkg::ONE_Q31_64) v = mwto_pkg::ONE_Q31_64;
      rom[k] = (quad >= 64'd2) ? mwto_pkg::VALUE_BITS'(-v) : mwto_pkg::VALUE_BITS'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine();

  logic [31:0]                              phase_acc;
  logic [31:0]                              noise_state;
  logic [31:0]                              noise_next;
  logic [31:0]                              x1;
  logic [31:0]                              x2;
  logic [31+DB:0]                           idx_prod;
  logic [KB-1:0]                            sine_idx;
  logic signed [mwto_pkg::VALUE_BITS-1:0]   rom_q;
  logic signed [mwto_pkg::VALUE_BITS-1:0]   other_q;
  logic signed [mwto_pkg::VALUE_BITS-1:0]   other_next;
  logic                                     use_sine;

  always_comb begin
    x1         = noise_state ^ (noise_state << 13);
    x2         = x1 ^ (x1 >> 17);
    noise_next = x2 ^ (x2 << 5);
  end

  // Table index is the top of phase times depth.
  assign idx_prod = {{DB{1'b0}}, phase_acc} * (32 + DB)'(SINE_TABLE_DEPTH);
  assign sine_idx = idx_prod[32 +: KB];

  always_comb begin
    case (cfg.waveform)
      mwto_pkg::WAVE_SQUARE:  other_next = phase_acc[31] ? -ONE : ONE;
      mwto_pkg::WAVE_SAW:     other_next = $signed({1'b0, phase_acc}) - ONE;
      mwto_pkg::WAVE_NOISE:   other_next = $signed({1'b0, noise_next}) - ONE;
      mwto_pkg::WAVE_IMPULSE: other_next = (phase_acc < {1'b0, cfg.phase_step}) ? ONE : '0;
      default:                other_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= '0;
      noise_state <= mwto_pkg::SEED_RESET;
    end else begin
      if (ctrl.seed_load) begin
        noise_state <= (ctrl.seed == 32'd0) ? mwto_pkg::SEED_RESET : ctrl.seed;
      end else if (ctrl.gen && !ctrl.quiet && cfg.waveform == mwto_pkg::WAVE_NOISE) begin
        noise_state <= noise_next;
      end
      if (ctrl.gen && !ctrl.quiet) begin
        phase_acc <= phase_acc + {1'b0, cfg.phase_step};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.gen) begin
      rom_q    <= SINE_ROM[sine_idx];
      other_q  <= ctrl.quiet ? '0 : other_next;
      use_sine <= !ctrl.quiet && cfg.waveform == mwto_pkg::WAVE_SINE;
    end
  end

  assign value = use_sine ? rom_q : other_q;

endmodule

// File: rtl/mwto_scale.sv
// Shared gain multiplier with round-half-up and saturation to the sample width.
module mwto_scale #(
  parameter int SAMPLE_BITS = mwto_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   mul_en,
  input  logic signed [mwto_pkg::VALUE_BITS-1:0] value,
  input  logic [mwto_pkg::GAIN_BITS-1:0]         gain,
  output logic signed [SAMPLE_BITS-1:0]          scaled
);

  localparam int PW = mwto_pkg::VALUE_BITS + mwto_pkg::GAIN_BITS + 1;
  localparam int SH = 47 - SAMPLE_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (SH - 1);
  localparam logic signed [PW-1:0] HI   = (PW'(1) <<< (SAMPLE_BITS - 1)) - PW'(1);
  localparam logic signed [PW-1:0] LO   = -HI - PW'(1);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PW'(value) * PW'($signed({1'b0, gain}));
    end
  end

  // Product is Q2.46; round half up, then clip to the sample range.
  assign shifted = (prod + HALF) >>> SH;

  always_comb begin
    if (shifted > HI) begin
      scaled = HI[SAMPLE_BITS-1:0];
    end else if (shifted < LO) begin
      scaled = LO[SAMPLE_BITS-1:0];
    end else begin
      scaled = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule
